[rtl/swt_pkg.sv]
// types, codes and the per-byte lexer step of the shell word tokenizer
package swt_pkg;

    localparam int ChWidth     = 8;
    localparam int KindWidth   = 2;
    localparam int OpWidth     = 3;
    localparam int MaxResults  = 3;
    localparam int CntWidth    = 2;
    localparam int TdataWidth  = 16;

    // result kinds
    localparam logic [KindWidth-1:0] KIND_CHAR = 2'd0;
    localparam logic [KindWidth-1:0] KIND_END  = 2'd1;
    localparam logic [KindWidth-1:0] KIND_OP   = 2'd2;
    localparam logic [KindWidth-1:0] KIND_LINE = 2'd3;

    // operator codes
    localparam logic [OpWidth-1:0] OP_PIPE   = 3'd0;
    localparam logic [OpWidth-1:0] OP_LESS   = 3'd1;
    localparam logic [OpWidth-1:0] OP_GREAT  = 3'd2;
    localparam logic [OpWidth-1:0] OP_APPEND = 3'd3;
    localparam logic [OpWidth-1:0] OP_AMP    = 3'd4;
    localparam logic [OpWidth-1:0] OP_NONE   = 3'd0;

    // special bytes
    localparam logic [ChWidth-1:0] CH_SQUOTE = 8'h27;
    localparam logic [ChWidth-1:0] CH_DQUOTE = 8'h22;
    localparam logic [ChWidth-1:0] CH_BSLASH = 8'h5c;
    localparam logic [ChWidth-1:0] CH_DOLLAR = 8'h24;
    localparam logic [ChWidth-1:0] CH_HASH   = 8'h23;
    localparam logic [ChWidth-1:0] CH_PIPE   = 8'h7c;
    localparam logic [ChWidth-1:0] CH_LESS   = 8'h3c;
    localparam logic [ChWidth-1:0] CH_GREAT  = 8'h3e;
    localparam logic [ChWidth-1:0] CH_AMP    = 8'h26;
    localparam logic [ChWidth-1:0] CH_SPACE  = 8'h20;
    localparam logic [ChWidth-1:0] CH_TAB    = 8'h09;
    localparam logic [ChWidth-1:0] CH_CR     = 8'h0d;
    localparam logic [ChWidth-1:0] CH_NONE   = 8'h00;

    typedef enum logic [6:0] {
        MODE_NORMAL = 7'b0000001,
        MODE_SQ     = 7'b0000010,
        MODE_DQ     = 7'b0000100,
        MODE_DQBS   = 7'b0001000,
        MODE_BS     = 7'b0010000,
        MODE_GT     = 7'b0100000,
        MODE_CMT    = 7'b1000000
    } mode_t;

    typedef struct packed {
        logic [KindWidth-1:0] kind;
        logic [ChWidth-1:0]   ch;
        logic                 quoted;
        logic [OpWidth-1:0]   op;
    } res_t;

    typedef struct packed {
        res_t [MaxResults-1:0] res;
        logic [CntWidth-1:0]   cnt;
        mode_t                 mode;
        logic                  in_word;
        logic                  quoted;
    } lex_t;

    function automatic lex_t push(lex_t s, logic [KindWidth-1:0] kind,
                                  logic [ChWidth-1:0] ch, logic q,
                                  logic [OpWidth-1:0] op);
        lex_t r;
        r = s;
        if (s.cnt != CntWidth'(MaxResults)) begin
            r.res[s.cnt].kind   = kind;
            r.res[s.cnt].ch     = ch;
            r.res[s.cnt].quoted = q;
            r.res[s.cnt].op     = op;
            r.cnt               = s.cnt + 2'd1;
        end
        return r;
    endfunction

    function automatic lex_t end_word(lex_t s);
        lex_t r;
        r = s;
        if (s.in_word) begin
            r = push(r, KIND_END, CH_NONE, s.quoted, OP_NONE);
        end
        r.in_word = 1'b0;
        r.quoted  = 1'b0;
        return r;
    endfunction

    function automatic lex_t normal_byte(lex_t s, logic [ChWidth-1:0] c);
        lex_t r;
        logic is_space;
        r = s;
        is_space = (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
        if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            r.in_word = 1'b1;
            r.quoted  = 1'b1;
            r.mode    = (c == CH_SQUOTE) ? MODE_SQ : MODE_DQ;
        end else if (c == CH_BSLASH) begin
            r.mode = MODE_BS;
        end else if (is_space) begin
            r = end_word(r);
        end else if (c == CH_HASH && !s.in_word) begin
            r.mode = MODE_CMT;
        end else if (c == CH_PIPE) begin
            r = push(end_word(r), KIND_OP, CH_NONE, 1'b0, OP_PIPE);
        end else if (c == CH_LESS) begin
            r = push(end_word(r), KIND_OP, CH_NONE, 1'b0, OP_LESS);
        end else if (c == CH_AMP) begin
            r = push(end_word(r), KIND_OP, CH_NONE, 1'b0, OP_AMP);
        end else if (c == CH_GREAT) begin
            r      = end_word(r);
            r.mode = MODE_GT;
        end else begin
            r.in_word = 1'b1;
            r = push(r, KIND_CHAR, c, 1'b0, OP_NONE);
        end
        return r;
    endfunction

    function automatic lex_t lex_step(mode_t mode, logic in_word, logic quoted,
                                      logic [ChWidth-1:0] c, logic eol);
        lex_t s;
        s         = '0;
        s.mode    = mode;
        s.in_word = in_word;
        s.quoted  = quoted;
        if (eol) begin
            if (mode == MODE_BS) begin
                s.in_word = 1'b1;
                s = push(s, KIND_CHAR, CH_BSLASH, 1'b0, OP_NONE);
            end else if (mode == MODE_DQBS) begin
                s = push(s, KIND_CHAR, CH_BSLASH, 1'b0, OP_NONE);
            end else if (mode == MODE_GT) begin
                s = push(s, KIND_OP, CH_NONE, 1'b0, OP_GREAT);
            end
            s      = end_word(s);
            s      = push(s, KIND_LINE, CH_NONE, 1'b0, OP_NONE);
            s.mode = MODE_NORMAL;
        end else begin
            unique case (mode)
                MODE_SQ: begin
                    if (c == CH_SQUOTE) begin
                        s.mode = MODE_NORMAL;
                    end else begin
                        s = push(s, KIND_CHAR, c, 1'b0, OP_NONE);
                    end
                end
                MODE_DQ: begin
                    if (c == CH_DQUOTE) begin
                        s.mode = MODE_NORMAL;
                    end else if (c == CH_BSLASH) begin
                        s.mode = MODE_DQBS;
                    end else begin
                        s = push(s, KIND_CHAR, c, 1'b0, OP_NONE);
                    end
                end
                MODE_DQBS: begin
                    if (!(c == CH_DQUOTE || c == CH_BSLASH || c == CH_DOLLAR)) begin
                        s = push(s, KIND_CHAR, CH_BSLASH, 1'b0, OP_NONE);
                    end
                    s      = push(s, KIND_CHAR, c, 1'b0, OP_NONE);
                    s.mode = MODE_DQ;
                end
                MODE_BS: begin
                    s.in_word = 1'b1;
                    s         = push(s, KIND_CHAR, c, 1'b0, OP_NONE);
                    s.mode    = MODE_NORMAL;
                end
                MODE_GT: begin
                    s.mode = MODE_NORMAL;
                    if (c == CH_GREAT) begin
                        s = push(s, KIND_OP, CH_NONE, 1'b0, OP_APPEND);
                    end else begin
                        s = push(s, KIND_OP, CH_NONE, 1'b0, OP_GREAT);
                        s = normal_byte(s, c);
                    end
                end
                MODE_CMT: begin
                    s.mode = MODE_CMT;
                end
                default: begin
                    s.mode = MODE_NORMAL;
                    s      = normal_byte(s, c);
                end
            endcase
        end
        return s;
    endfunction

endpackage

[rtl/shell_word_tokenizer.sv]
// shell command line tokenizer: one byte per item in, word and operator items out
// the first result of an item is registered and valid the cycle after the item is accepted
// throughput: one item per cycle while items give at most one result each and m_tready is high
// an item giving n results (up to 3) stalls the input until the result queue holds
// one result and m_tready is high; items with no result never stall the input
// reset: synchronous active-low aresetn returns the lexer to normal mode, no open word, empty queue
module shell_word_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch[7:0]
    input  logic        s_tlast,   // end of line
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // ch_res[7:0], quoted[8], op[11:9], zero[15:12]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);
    import swt_pkg::*;

    mode_t                       mode_reg;
    logic                        in_word_reg;
    logic                        quoted_reg;
    res_t [MaxResults-1:0]       res_reg;
    logic [CntWidth-1:0]         cnt_reg;

    lex_t                        lex;
    logic                        accept;
    logic                        pop;

    assign pop      = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == '0) || (cnt_reg == CntWidth'(1) && m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        lex = lex_step(mode_reg, in_word_reg, quoted_reg, s_tdata, s_tlast);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_NORMAL;
            in_word_reg <= 1'b0;
            quoted_reg  <= 1'b0;
            cnt_reg     <= '0;
        end else if (accept) begin
            mode_reg    <= lex.mode;
            in_word_reg <= lex.in_word;
            quoted_reg  <= lex.quoted;
            cnt_reg     <= lex.cnt;
        end else if (pop) begin
            cnt_reg     <= cnt_reg - CntWidth'(1);
        end
    end

    // pending results, head at index 0
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= lex.res;
        end else if (pop) begin
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
        end
    end

    assign m_tvalid = cnt_reg != '0;
    assign m_tlast  = cnt_reg == CntWidth'(1);
    assign m_tuser  = res_reg[0].kind;
    assign m_tdata  = {{(TdataWidth - ChWidth - 1 - OpWidth){1'b0}},
                       res_reg[0].op, res_reg[0].quoted, res_reg[0].ch};

endmodule

[test/tb_shell_word_tokenizer.sv]
// testbench for the shell word tokenizer: byte stream in, predicted tokens checked out
module tb_shell_word_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    import swt_pkg::*;

    localparam int ItemCount  = 220;
    localparam int HoldAt     = 60;
    localparam int HoldCycles = 90;
    localparam int DrainWait  = 10;
    localparam int CycleLimit = 200000;

    localparam logic [8:0] EOL = 9'h100;

    typedef struct packed {
        logic [KindWidth-1:0] kind;
        logic [ChWidth-1:0]   ch;
        logic                 quoted;
        logic [OpWidth-1:0]   op;
        logic                 last;
    } token_t;

    class token_scoreboard;
        mode_t  mode;
        bit     word_open;
        bit     word_quoted;
        token_t tokens_due[$];
        token_t burst[$];
        int     errors;

        function new();
            mode        = MODE_NORMAL;
            word_open   = 1'b0;
            word_quoted = 1'b0;
            errors      = 0;
        endfunction

        function void emit(logic [KindWidth-1:0] kind, logic [ChWidth-1:0] c, logic q,
                           logic [OpWidth-1:0] op);
            token_t t;
            t.kind   = kind;
            t.ch     = c;
            t.quoted = q;
            t.op     = op;
            t.last   = 1'b0;
            if (burst.size() < MaxResults) begin
                burst.push_back(t);
            end
        endfunction

        function void close_word();
            if (word_open) begin
                emit(KIND_END, CH_NONE, word_quoted, OP_NONE);
            end
            word_open   = 1'b0;
            word_quoted = 1'b0;
        endfunction

        function void plain_byte(logic [ChWidth-1:0] c);
            case (c)
                CH_SQUOTE, CH_DQUOTE: begin
                    word_open   = 1'b1;
                    word_quoted = 1'b1;
                    mode        = (c == CH_SQUOTE) ? MODE_SQ : MODE_DQ;
                end
                CH_BSLASH: mode = MODE_BS;
                CH_PIPE: begin
                    close_word();
                    emit(KIND_OP, CH_NONE, 1'b0, OP_PIPE);
                end
                CH_LESS: begin
                    close_word();
                    emit(KIND_OP, CH_NONE, 1'b0, OP_LESS);
                end
                CH_AMP: begin
                    close_word();
                    emit(KIND_OP, CH_NONE, 1'b0, OP_AMP);
                end
                CH_GREAT: begin
                    close_word();
                    mode = MODE_GT;
                end
                default: begin
                    if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) begin
                        close_word();
                    end else if (c == CH_HASH && !word_open) begin
                        mode = MODE_CMT;
                    end else begin
                        word_open = 1'b1;
                        emit(KIND_CHAR, c, 1'b0, OP_NONE);
                    end
                end
            endcase
        endfunction

        // predict the tokens caused by one accepted item
        function void lex_byte(logic [ChWidth-1:0] c, logic eol);
            token_t t;
            burst.delete();
            if (eol) begin
                case (mode)
                    MODE_BS: begin
                        word_open = 1'b1;
                        emit(KIND_CHAR, CH_BSLASH, 1'b0, OP_NONE);
                    end
                    MODE_DQBS: emit(KIND_CHAR, CH_BSLASH, 1'b0, OP_NONE);
                    MODE_GT:   emit(KIND_OP, CH_NONE, 1'b0, OP_GREAT);
                    default: ;
                endcase
                close_word();
                emit(KIND_LINE, CH_NONE, 1'b0, OP_NONE);
                mode = MODE_NORMAL;
            end else begin
                case (mode)
                    MODE_SQ: begin
                        if (c == CH_SQUOTE) begin
                            mode = MODE_NORMAL;
                        end else begin
                            emit(KIND_CHAR, c, 1'b0, OP_NONE);
                        end
                    end
                    MODE_DQ: begin
                        if (c == CH_DQUOTE) begin
                            mode = MODE_NORMAL;
                        end else if (c == CH_BSLASH) begin
                            mode = MODE_DQBS;
                        end else begin
                            emit(KIND_CHAR, c, 1'b0, OP_NONE);
                        end
                    end
                    MODE_DQBS: begin
                        if (c != CH_DQUOTE && c != CH_BSLASH && c != CH_DOLLAR) begin
                            emit(KIND_CHAR, CH_BSLASH, 1'b0, OP_NONE);
                        end
                        emit(KIND_CHAR, c, 1'b0, OP_NONE);
                        mode = MODE_DQ;
                    end
                    MODE_BS: begin
                        word_open = 1'b1;
                        emit(KIND_CHAR, c, 1'b0, OP_NONE);
                        mode = MODE_NORMAL;
                    end
                    MODE_GT: begin
                        mode = MODE_NORMAL;
                        if (c == CH_GREAT) begin
                            emit(KIND_OP, CH_NONE, 1'b0, OP_APPEND);
                        end else begin
                            emit(KIND_OP, CH_NONE, 1'b0, OP_GREAT);
                            plain_byte(c);
                        end
                    end
                    MODE_CMT: ;
                    default: begin
                        mode = MODE_NORMAL;
                        plain_byte(c);
                    end
                endcase
            end
            foreach (burst[i]) begin
                t      = burst[i];
                t.last = (i == burst.size() - 1);
                tokens_due.push_back(t);
            end
        endfunction

        function void report_diff(string field, logic [15:0] want, logic [15:0] got);
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            errors++;
        endfunction

        function void check_token(logic [15:0] data, logic [1:0] kind, logic last);
            token_t want;
            if (tokens_due.size() == 0) begin
                $display("%0t: unexpected item, expected none, got kind %0h data %0h last %0h",
                         $time, kind, data, last);
                errors++;
                return;
            end
            want = tokens_due.pop_front();
            if (kind !== want.kind)
                report_diff("kind", 16'(want.kind), 16'(kind));
            if (data[7:0] !== want.ch)
                report_diff("ch", 16'(want.ch), 16'(data[7:0]));
            if (data[8] !== want.quoted)
                report_diff("quoted", 16'(want.quoted), 16'(data[8]));
            if (data[11:9] !== want.op)
                report_diff("op", 16'(want.op), 16'(data[11:9]));
            if (data[15:12] !== 4'h0)
                report_diff("pad", 16'h0, 16'(data[15:12]));
            if (last !== want.last)
                report_diff("last", 16'(want.last), 16'(last));
        endfunction

        function int pending();
            return tokens_due.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    token_scoreboard sb = new();

    int n_sent      = 0;
    int rx_count    = 0;
    int cycles      = 0;
    bit idle_on     = 1'b1;
    bit rx_holding  = 1'b0;

    logic [8:0] script [30] = '{
        {1'b0, CH_NONE}, {1'b0, CH_HASH}, {1'b0, CH_TAB}, {1'b0, CH_HASH}, {1'b0, CH_PIPE}, EOL,
        {1'b0, CH_SQUOTE}, {1'b0, CH_SQUOTE}, {1'b0, CH_AMP},
        {1'b0, CH_DQUOTE}, {1'b0, CH_BSLASH}, {1'b0, 8'h78}, {1'b0, CH_BSLASH},
        {1'b0, CH_DOLLAR}, {1'b0, CH_BSLASH}, EOL,
        {1'b0, CH_GREAT}, {1'b0, CH_GREAT}, {1'b0, CH_GREAT}, {1'b0, 8'h61},
        {1'b0, CH_LESS}, {1'b0, CH_BSLASH}, EOL,
        {1'b0, CH_GREAT}, EOL,
        {1'b0, CH_BSLASH}, {1'b0, CH_SPACE}, {1'b0, CH_DQUOTE}, {1'b0, 8'hff}, 9'h1ff
    };

    shell_word_tokenizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] c, input logic eol);
        int gap;
        gap = (idle_on && !rx_holding) ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eol;
        do @(posedge aclk); while (!s_tready);
        sb.lex_byte(c, eol);
        n_sent++;
    endtask

    task automatic send_noise();
        logic [7:0] b;
        repeat ($urandom_range(3, 10)) begin
            b = 8'($urandom_range(0, 255));
            send_item(b, $urandom_range(0, 15) == 0);
        end
        b = 8'($urandom_range(0, 255));
        send_item(b, 1'b1);
    endtask

    // a command line built from words, quotes, escapes, operators and comments
    task automatic send_line();
        logic [7:0] b;
        int         r;
        repeat ($urandom_range(1, 7)) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    repeat ($urandom_range(1, 4)) begin
                        if ($urandom_range(0, 3) == 0) begin
                            b = 8'($urandom_range(0, 255));
                        end else begin
                            b = 8'h61 + 8'($urandom_range(0, 25));
                        end
                        send_item(b, 1'b0);
                    end
                end
                3: begin
                    send_item(CH_SQUOTE, 1'b0);
                    repeat ($urandom_range(0, 3)) begin
                        b = 8'($urandom_range(0, 255));
                        send_item(b, 1'b0);
                    end
                    if ($urandom_range(0, 7) != 0) send_item(CH_SQUOTE, 1'b0);
                end
                4: begin
                    send_item(CH_DQUOTE, 1'b0);
                    repeat ($urandom_range(0, 3)) begin
                        if ($urandom_range(0, 2) == 0) begin
                            send_item(CH_BSLASH, 1'b0);
                            r = $urandom_range(0, 3);
                            b = (r == 0) ? CH_DQUOTE : (r == 1) ? CH_BSLASH :
                                (r == 2) ? CH_DOLLAR : 8'($urandom_range(0, 255));
                        end else begin
                            b = 8'($urandom_range(0, 255));
                        end
                        send_item(b, 1'b0);
                    end
                    if ($urandom_range(0, 7) != 0) send_item(CH_DQUOTE, 1'b0);
                end
                5: begin
                    send_item(CH_BSLASH, 1'b0);
                    b = 8'($urandom_range(0, 255));
                    send_item(b, 1'b0);
                end
                6: begin
                    case ($urandom_range(0, 4))
                        0: send_item(CH_PIPE, 1'b0);
                        1: send_item(CH_LESS, 1'b0);
                        2: send_item(CH_GREAT, 1'b0);
                        3: begin
                            send_item(CH_GREAT, 1'b0);
                            send_item(CH_GREAT, 1'b0);
                        end
                        default: send_item(CH_AMP, 1'b0);
                    endcase
                end
                7: begin
                    r = $urandom_range(0, 5);
                    b = (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
                    send_item(b, 1'b0);
                end
                8: begin
                    send_item(CH_HASH, 1'b0);
                    repeat ($urandom_range(0, 3)) begin
                        b = 8'($urandom_range(0, 255));
                        send_item(b, 1'b0);
                    end
                end
                default: begin
                    b = 8'($urandom_range(0, 255));
                    send_item(b, 1'b0);
                end
            endcase
        end
        b = 8'($urandom_range(0, 255));
        send_item(b, 1'b1);
    endtask

    // result side, with one long hold-off so the block backs up
    initial begin
        int pause;
        @(posedge aresetn);
        forever begin
            if (rx_count == HoldAt) begin
                rx_holding = 1'b1;
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
                rx_holding = 1'b0;
            end else begin
                pause = idle_on ? $urandom_range(0, 7) : 0;
                if (pause > 0) begin
                    @(negedge aclk);
                    m_tready <= 1'b0;
                    repeat (pause) @(posedge aclk);
                end
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_token(m_tdata, m_tuser, m_tlast);
            rx_count++;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) send_item(script[i][7:0], script[i][8]);

        while (n_sent < ItemCount) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) begin
                send_noise();
            end else begin
                send_line();
            end
        end
        idle_on = 1'b1;
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DrainWait) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
